/* rtl/kct_pkg.sv */
`default_nettype none

package kct_pkg;

  localparam int unsigned Entries = 256;
  localparam int unsigned IdxW    = $clog2(Entries);
  localparam int unsigned CntW    = $clog2(Entries + 1);

  localparam logic [31:0] AdminPin = 32'h3030_3030;
  localparam logic [7:0]  AdminId  = 8'd0;

  typedef enum logic [1:0] {
    CMD_ENROLL = 2'd0,
    CMD_VERIFY = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_ENROLLED = 3'd0,
    ST_EXISTS   = 3'd1,
    ST_FULL     = 3'd2,
    ST_GRANTED  = 3'd3,
    ST_WRONG    = 3'd4,
    ST_UNKNOWN  = 3'd5,
    ST_CLEARED  = 3'd6,
    ST_BADKEY   = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_e;

  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] pin;
  } record_t;

  function automatic logic key_ok(input logic [7:0] k);
    key_ok = (k >= 8'd48 && k <= 8'd57) || (k >= 8'd65 && k <= 8'd68) ||
             k == 8'd42 || k == 8'd35;
  endfunction

  function automatic logic id_ok(input logic [7:0] k);
    id_ok = (k == AdminId) || key_ok(k);
  endfunction

endpackage

`default_nettype wire

/* rtl/keypad_credential_table.sv */
// Keypad credential table: enroll, verify or clear one request at a time.
// Each request scans every occupied record in turn (one read per record, through
// a registered read port), then closes the scan and decides the result.
// A new request is taken only once the result is out; a stalled output holds it.
// Reset: asynchronous; the table holds only the administrator record, with
// no clearing pass (occupied records are tracked by the fill count).
`default_nettype none

module keypad_credential_table
  import kct_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [7:0]  user_id_i,
  input  wire logic [7:0]  digit0_i,
  input  wire logic [7:0]  digit1_i,
  input  wire logic [7:0]  digit2_i,
  input  wire logic [7:0]  digit3_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [2:0]  status_o
);

  record_t mem [Entries];
  record_t rd_data_q;

  state_e          state_q, state_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic [CntW-1:0] issue_q, issue_d;
  logic            pend_q, pend_d;
  logic            rd_zero_q, rd_zero_d;
  logic            admin_q, admin_d;
  logic            found_q, found_d;
  logic            match_q, match_d;
  logic            keys_ok_q;
  cmd_e            cmd_q;
  record_t         req_q;
  logic            out_valid_q, out_valid_d;
  status_e         status_q, status_d;

  logic            accept;
  logic            issue;
  logic            out_free;
  logic            wr_en;
  record_t         rd_rec;

  assign accept   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign issue    = (state_q == S_SCAN) && (issue_q < fill_q);
  assign rd_rec   = (rd_zero_q && admin_q) ? record_t'{id: AdminId, pin: AdminPin}
                                           : rd_data_q;

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    issue_d     = issue_q;
    pend_d      = 1'b0;
    rd_zero_d   = rd_zero_q;
    admin_d     = admin_q;
    found_d     = found_q;
    match_d     = match_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    wr_en       = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_SCAN;
          issue_d = '0;
          found_d = 1'b0;
          match_d = 1'b0;
        end
      end
      S_SCAN: begin
        if (issue) begin
          issue_d   = issue_q + 1'b1;
          pend_d    = 1'b1;
          rd_zero_d = (issue_q == '0);
        end
        if (pend_q && rd_rec.id == req_q.id) begin
          found_d = 1'b1;
          if (rd_rec.pin == req_q.pin) begin
            match_d = 1'b1;
          end
        end
        if (!issue && !pend_q) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          case (cmd_q)
            CMD_ENROLL: begin
              if (!keys_ok_q) begin
                status_d = ST_BADKEY;
              end else if (found_q) begin
                status_d = ST_EXISTS;
              end else if (fill_q >= CntW'(Entries)) begin
                status_d = ST_FULL;
              end else begin
                status_d = ST_ENROLLED;
                wr_en    = 1'b1;
                fill_d   = fill_q + 1'b1;
                if (fill_q == '0) begin
                  admin_d = 1'b0;
                end
              end
            end
            CMD_VERIFY: begin
              if (!keys_ok_q) begin
                status_d = ST_BADKEY;
              end else if (!found_q) begin
                status_d = ST_UNKNOWN;
              end else if (match_q) begin
                status_d = ST_GRANTED;
              end else begin
                status_d = ST_WRONG;
              end
            end
            CMD_CLEAR: begin
              status_d = ST_CLEARED;
              fill_d   = '0;
            end
            default: begin
              status_d = ST_BADKEY;
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= CntW'(1);
      issue_q     <= '0;
      pend_q      <= 1'b0;
      rd_zero_q   <= 1'b0;
      admin_q     <= 1'b1;
      found_q     <= 1'b0;
      match_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      issue_q     <= issue_d;
      pend_q      <= pend_d;
      rd_zero_q   <= rd_zero_d;
      admin_q     <= admin_d;
      found_q     <= found_d;
      match_q     <= match_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q     <= cmd_e'(cmd_i);
      req_q     <= '{id: user_id_i, pin: {digit3_i, digit2_i, digit1_i, digit0_i}};
      keys_ok_q <= id_ok(user_id_i) && key_ok(digit0_i) && key_ok(digit1_i) &&
                   key_ok(digit2_i) && key_ok(digit3_i);
    end
    status_q <= status_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[fill_q[IdxW-1:0]] <= req_q;
    end
    if (issue) begin
      rd_data_q <= mem[issue_q[IdxW-1:0]];
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;

`ifndef NO_ASSERTIONS
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(Entries))
    else $error("fill count beyond table size");

  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (issue_q <= fill_q))
    else $error("scan ran past occupied records");

  a_match_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    match_q |-> found_q)
    else $error("match without matching id");

  a_enroll_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> (fill_q == $past(fill_q) + 1'b1) && (status_q == ST_ENROLLED))
    else $error("enroll did not advance fill count");
`endif

endmodule

`default_nettype wire
